>>> rtl/udict_pkg.sv
// ----------------------------------------------------------------------------
// udict_pkg
// Shared types, sizes and codes of the unique word dictionary.
// ----------------------------------------------------------------------------
package udict_pkg;

	localparam int MAX_WORD_LEN = 64;
	localparam int DICT_ENTRIES = 256;

	// byte position inside a word, word length, entry index, entry count
	localparam int POS_W = $clog2(MAX_WORD_LEN);
	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int ENT_W = $clog2(DICT_ENTRIES);
	localparam int CNT_W = $clog2(DICT_ENTRIES + 1);

	// entry byte store is addressed as {entry, position}
	localparam int BADDR_W = ENT_W + POS_W;
	localparam int BYTES_DEPTH = DICT_ENTRIES << POS_W;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic       is_new;
		logic [7:0] entry_index;
		logic [8:0] unique_count;
		logic       dictionary_full;
		logic       word_truncated;
		logic [6:0] word_length;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN_RD,
		ST_LEN_CMP,
		ST_BYTE_RD,
		ST_BYTE_CMP,
		ST_MISS,
		ST_CP_RD,
		ST_CP_WR
	} state_t;

	// memory controls driven by the sequencer
	typedef struct packed {
		logic               wb_we;
		logic [POS_W-1:0]   wb_waddr;
		logic [7:0]         wb_wdata;
		logic [POS_W-1:0]   wb_raddr;
		logic               len_we;
		logic [ENT_W-1:0]   len_waddr;
		logic [LEN_W-1:0]   len_wdata;
		logic [ENT_W-1:0]   len_raddr;
		logic               eb_we;
		logic [BADDR_W-1:0] eb_waddr;
		logic [7:0]         eb_wdata;
		logic [BADDR_W-1:0] eb_raddr;
	} mem_ctrl_t;

	// registered read data returned to the sequencer
	typedef struct packed {
		logic [7:0]       wb_rdata;
		logic [LEN_W-1:0] len_rdata;
		logic [7:0]       eb_rdata;
	} mem_rd_t;

endpackage

>>> rtl/udict_ram.sv
// ----------------------------------------------------------------------------
// udict_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module udict_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/udict_seq.sv
// ----------------------------------------------------------------------------
// udict_seq
// Word gathering and search/insert sequencer around one byte comparator.
// ----------------------------------------------------------------------------
module udict_seq import udict_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	input  logic      out_free,
	output logic      done,
	output out_item_t res,
	output mem_ctrl_t mem,
	input  mem_rd_t   rd
);

	state_t           state_q, state_d;
	logic [LEN_W-1:0] fill_q, fill_d;
	logic             ovf_q, ovf_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [ENT_W-1:0] ent_q, ent_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             new_q, new_d;
	logic             full_q, full_d;
	logic [ENT_W-1:0] idx_q, idx_d;
	logic             pend_q, pend_d;

	logic accept;
	logic delim;
	logic last_ent;
	logic last_pos;

	assign char_ready = (state_q == ST_IDLE) && !pend_q;
	assign accept = char_valid && char_ready;
	assign delim = char_item.end_of_text
		|| (char_item.char_code inside {CH_SPACE, CH_NEWLINE});
	assign last_ent = (CNT_W'(ent_q) + CNT_W'(1)) == count_q;
	assign last_pos = (LEN_W'(pos_q) + LEN_W'(1)) == fill_q;

	assign res.is_new = new_q;
	assign res.entry_index = 8'(idx_q);
	assign res.unique_count = 9'(count_q);
	assign res.dictionary_full = full_q;
	assign res.word_truncated = ovf_q;
	assign res.word_length = 7'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			ovf_q   <= ovf_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q  <= ent_d;
		pos_q  <= pos_d;
		new_q  <= new_d;
		full_q <= full_d;
		idx_q  <= idx_d;
	end

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		ovf_d   = ovf_q;
		count_d = count_q;
		ent_d   = ent_q;
		pos_d   = pos_q;
		new_d   = new_q;
		full_d  = full_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		done    = 1'b0;
		mem     = '0;

		case (state_q)
			ST_IDLE: begin
				// a finished result waits here until the output register frees up
				if (pend_q) begin
					if (out_free) begin
						done   = 1'b1;
						pend_d = 1'b0;
						fill_d = '0;
						ovf_d  = 1'b0;
					end
				end else if (accept) begin
					if (!delim) begin
						if (fill_q < LEN_W'(MAX_WORD_LEN)) begin
							mem.wb_we    = 1'b1;
							mem.wb_waddr = POS_W'(fill_q);
							mem.wb_wdata = char_item.char_code;
							fill_d       = fill_q + LEN_W'(1);
						end else begin
							ovf_d = 1'b1;
						end
					end else if (fill_q == '0) begin
						ovf_d = 1'b0;
					end else begin
						ent_d   = '0;
						state_d = (count_q == '0) ? ST_MISS : ST_LEN_RD;
					end
				end
			end
			ST_LEN_RD: begin
				mem.len_raddr = ent_q;
				state_d       = ST_LEN_CMP;
			end
			ST_LEN_CMP: begin
				if (rd.len_rdata == fill_q) begin
					pos_d   = '0;
					state_d = ST_BYTE_RD;
				end else if (last_ent) begin
					state_d = ST_MISS;
				end else begin
					ent_d   = ent_q + ENT_W'(1);
					state_d = ST_LEN_RD;
				end
			end
			ST_BYTE_RD: begin
				mem.wb_raddr = pos_q;
				mem.eb_raddr = {ent_q, pos_q};
				state_d      = ST_BYTE_CMP;
			end
			ST_BYTE_CMP: begin
				if (rd.wb_rdata != rd.eb_rdata) begin
					if (last_ent) begin
						state_d = ST_MISS;
					end else begin
						ent_d   = ent_q + ENT_W'(1);
						state_d = ST_LEN_RD;
					end
				end else if (last_pos) begin
					new_d   = 1'b0;
					full_d  = 1'b0;
					idx_d   = ent_q;
					pend_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					pos_d   = pos_q + POS_W'(1);
					state_d = ST_BYTE_RD;
				end
			end
			ST_MISS: begin
				new_d = 1'b1;
				if (count_q < CNT_W'(DICT_ENTRIES)) begin
					mem.len_we    = 1'b1;
					mem.len_waddr = ENT_W'(count_q);
					mem.len_wdata = fill_q;
					full_d        = 1'b0;
					pos_d         = '0;
					state_d       = ST_CP_RD;
				end else begin
					// no free entry: word dropped, index reads as zero
					full_d  = 1'b1;
					idx_d   = '0;
					pend_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CP_RD: begin
				mem.wb_raddr = pos_q;
				state_d      = ST_CP_WR;
			end
			ST_CP_WR: begin
				mem.eb_we    = 1'b1;
				mem.eb_waddr = {ENT_W'(count_q), pos_q};
				mem.eb_wdata = rd.wb_rdata;
				if (last_pos) begin
					idx_d   = ENT_W'(count_q);
					count_d = count_q + CNT_W'(1);
					pend_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					pos_d   = pos_q + POS_W'(1);
					state_d = ST_CP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/unique_word_dictionary_core.sv
// ----------------------------------------------------------------------------
// unique_word_dictionary_core
// Builds a dictionary of distinct words from a byte stream.
// ----------------------------------------------------------------------------
// Text bytes are taken one per cycle and gathered into a word buffer; a
// space, newline or end-of-text item closes the word. A non-empty word is
// then searched against the stored entries in order by one shared byte
// comparator and, if absent, copied into the next free entry; when no
// entry is free the word is dropped. While the search or copy runs the
// input is not ready. The search reads the length of each stored entry
// visited and compares bytes only on entries of equal length; a new word
// is copied byte by byte through the registered read of the word buffer.
// The finished result is then held in the sequencer until it moves into the
// output register, and the input stays not ready until it has moved; it
// waits there while the output register still holds an unaccepted item.
// No memory clearing is needed after reset.
module unique_word_dictionary_core import udict_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	mem_ctrl_t mem;
	mem_rd_t   rd;
	out_item_t res;
	logic      done;
	logic      out_free;
	logic      valid_q;
	out_item_t result_q;

	assign out_free = !valid_q || result_ready;

	udict_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.out_free   (out_free),
		.done       (done),
		.res        (res),
		.mem        (mem),
		.rd         (rd)
	);

	// current word
	udict_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN)) u_word_buf (
		.clk   (clk),
		.we    (mem.wb_we),
		.waddr (mem.wb_waddr),
		.wdata (mem.wb_wdata),
		.raddr (mem.wb_raddr),
		.rdata (rd.wb_rdata)
	);

	// entry lengths; only entries below the stored count are ever read
	udict_ram #(.WIDTH(LEN_W), .DEPTH(DICT_ENTRIES)) u_entry_len (
		.clk   (clk),
		.we    (mem.len_we),
		.waddr (mem.len_waddr),
		.wdata (mem.len_wdata),
		.raddr (mem.len_raddr),
		.rdata (rd.len_rdata)
	);

	udict_ram #(.WIDTH(8), .DEPTH(BYTES_DEPTH)) u_entry_bytes (
		.clk   (clk),
		.we    (mem.eb_we),
		.waddr (mem.eb_waddr),
		.wdata (mem.eb_wdata),
		.raddr (mem.eb_raddr),
		.rdata (rd.eb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			result_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

	a_done_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_free)
		else $error("result loaded while output register still held an item");

	a_full_is_new: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dictionary_full |-> result.is_new)
		else $error("full flag on a word that was found");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.word_length != 7'd0)
		else $error("result for an empty word");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && (char_item.end_of_text
		|| char_item.char_code == CH_SPACE || char_item.char_code == CH_NEWLINE)
		&& (res.word_length != 7'd0) |=> !char_ready)
		else $error("input ready during search");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks unique_word_dictionary_core against a behavioral dictionary model.
// ----------------------------------------------------------------------------
// Bytes go in on the char channel and results come back on the result
// channel. A scoreboard tracks the word buffer and the stored entries,
// predicts one result per non-empty word and compares every field.
// Stimulus runs a few hand-picked words first, then three random phases:
// - a mixed phase of repeated and fresh words, long words and noise
// - a phase that fills the dictionary
// - a phase with the dictionary full
// Both channels stall at random, with quiet stretches in between.
module testbench import udict_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_GAP = 60;
	localparam int VOCAB_N = 48;

	class dict_scoreboard;
		logic [7:0] word_text [MAX_WORD_LEN];
		int         word_fill;
		bit         word_cut;
		int         entry_len [DICT_ENTRIES];
		logic [7:0] entry_text [DICT_ENTRIES][MAX_WORD_LEN];
		int         len_census [MAX_WORD_LEN + 1];
		int         stored;
		out_item_t  expected [$];
		int         mismatches;
		int         results_seen;
		int         new_words;
		int         known_words;
		int         dropped;
		int         truncated;
		int         empty_delims;
		longint     cycle_budget;

		function string fmt_result(out_item_t it);
			return $sformatf("new=%0d idx=%0d count=%0d full=%0d trunc=%0d len=%0d",
				it.is_new, it.entry_index, it.unique_count, it.dictionary_full,
				it.word_truncated, it.word_length);
		endfunction

		// predict the effect of one accepted byte or delimiter
		function void note_item(in_item_t it);
			out_item_t want;
			int        hit;
			int        e;
			int        k;
			bit        same;
			cycle_budget += MAX_GAP + 4;
			if (!it.end_of_text && it.char_code != CH_SPACE && it.char_code != CH_NEWLINE) begin
				if (word_fill < MAX_WORD_LEN) begin
					word_text[word_fill] = it.char_code;
					word_fill++;
				end else begin
					word_cut = 1'b1;
				end
				return;
			end
			if (word_fill == 0) begin
				word_cut = 1'b0;
				empty_delims++;
				return;
			end
			// upper bound on search, copy and result stall for the watchdog
			cycle_budget += 2 * stored + 2 * (word_fill + 1) * len_census[word_fill]
				+ 2 * word_fill + 1 + MAX_GAP + 8;
			hit = -1;
			for (e = 0; e < stored && hit < 0; e++) begin
				if (entry_len[e] == word_fill) begin
					same = 1'b1;
					for (k = 0; k < word_fill; k++)
						if (entry_text[e][k] != word_text[k])
							same = 1'b0;
					if (same)
						hit = e;
				end
			end
			want.is_new = (hit < 0);
			want.dictionary_full = 1'b0;
			if (hit >= 0) begin
				known_words++;
			end else if (stored < DICT_ENTRIES) begin
				hit = stored;
				entry_len[hit] = word_fill;
				for (k = 0; k < word_fill; k++)
					entry_text[hit][k] = word_text[k];
				len_census[word_fill]++;
				stored++;
				new_words++;
			end else begin
				hit = 0;
				want.dictionary_full = 1'b1;
				dropped++;
			end
			if (word_cut)
				truncated++;
			want.entry_index = 8'(hit);
			want.unique_count = 9'(stored);
			want.word_truncated = word_cut;
			want.word_length = 7'(word_fill);
			expected.push_back(want);
			word_fill = 0;
			word_cut = 1'b0;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			string     diffs;
			results_seen++;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: %s", results_seen, fmt_result(got));
				return;
			end
			want = expected.pop_front();
			diffs = "";
			if (got.is_new !== want.is_new) diffs = {diffs, " is_new"};
			if (got.entry_index !== want.entry_index) diffs = {diffs, " entry_index"};
			if (got.unique_count !== want.unique_count) diffs = {diffs, " unique_count"};
			if (got.dictionary_full !== want.dictionary_full) diffs = {diffs, " dictionary_full"};
			if (got.word_truncated !== want.word_truncated) diffs = {diffs, " word_truncated"};
			if (got.word_length !== want.word_length) diffs = {diffs, " word_length"};
			if (diffs != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d mismatch in%s\n  expected %s\n  actual   %s",
						results_seen, diffs, fmt_result(want), fmt_result(got));
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_ready;
	in_item_t  char_item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	dict_scoreboard sb = new();
	bit             idle_on;
	int             items_sent;
	longint         cycles;
	logic [7:0]     vocab_text [VOCAB_N][MAX_WORD_LEN];
	int             vocab_len [VOCAB_N];

	unique_word_dictionary_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_item    (char_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 4 * sb.cycle_budget + 200000) begin
			$display("testbench: timeout after %0d cycles, %0d results pending",
				cycles, sb.expected.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// results are checked before the item of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(result);
			if (char_valid && char_ready)
				sb.note_item(char_item);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!idle_on || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(MAX_GAP, 8);
	endfunction

	// word byte with the extremes favored; never a delimiter
	function automatic logic [7:0] rand_letter();
		logic [7:0] b;
		case ($urandom_range(7))
			0: b = 8'h00;
			1: b = 8'hFF;
			default: begin
				b = 8'($urandom_range(255));
				while (b == CH_SPACE || b == CH_NEWLINE)
					b = 8'($urandom_range(255));
			end
		endcase
		return b;
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic [7:0] code, input logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_item <= '{char_code: code, end_of_text: eot};
		char_valid <= 1'b1;
		do @(posedge clk); while (!char_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_delim();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			send_item(CH_SPACE, 1'b0);
		else if (r < 8)
			send_item(CH_NEWLINE, 1'b0);
		else
			send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_vocab(input int idx, input int tail);
		for (int k = 0; k < vocab_len[idx]; k++)
			send_item(vocab_text[idx][k], 1'b0);
		repeat (tail) send_item(rand_letter(), 1'b0);
		send_delim();
	endtask

	task automatic send_fresh(input int len);
		repeat (len) send_item(rand_letter(), 1'b0);
		send_delim();
	endtask

	task automatic send_noise();
		repeat ($urandom_range(6, 1))
			send_item(($urandom_range(3) == 0) ? CH_SPACE : 8'($urandom_range(255)),
				$urandom_range(9) == 0);
	endtask

	// always waits for a falling edge, so valid is never lowered and raised at once
	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(negedge clk); while (sb.expected.size() != 0);
	endtask

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin
		int r;
		// groups of three words share length, each differing from the one before
		// in at most one byte, so the search compares deep into equal-length entries
		for (int i = 0; i < VOCAB_N; i++) begin
			if (i < 3)
				vocab_len[i] = MAX_WORD_LEN;
			else if (i % 3 == 0)
				vocab_len[i] = $urandom_range(8, 1);
			else
				vocab_len[i] = vocab_len[i - 1];
			for (int k = 0; k < vocab_len[i]; k++)
				vocab_text[i][k] = (i % 3 != 0) ? vocab_text[i - 1][k] : rand_letter();
			if (i % 3 != 0)
				vocab_text[i][$urandom_range(vocab_len[i] - 1)] = rand_letter();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero and top bytes, every delimiter, empty words,
		// repeats, and words after end of text
		idle_on = 1'b0;
		send_item(8'h41, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_NEWLINE, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(CH_NEWLINE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h78, 1'b1);
		send_item(8'h00, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(CH_SPACE, 1'b1);
		wait_drained();

		// mixed text: repeats, fresh words, long words, noise, empty words
		idle_on = 1'b1;
		while (items_sent < 370) begin
			r = $urandom_range(99);
			if (r < 55)
				send_vocab($urandom_range(VOCAB_N - 1, 3), 0);
			else if (r < 70)
				send_fresh($urandom_range(6, 1));
			else if (r < 76)
				send_vocab($urandom_range(2), $urandom_range(8));
			else if (r < 88)
				send_noise();
			else
				send_delim();
		end
		wait_drained();

		// fill the dictionary; the first part runs without any idling
		idle_on = 1'b0;
		while (sb.stored < DICT_ENTRIES) begin
			if (sb.stored > 160)
				idle_on = 1'b1;
			if ($urandom_range(9) == 0)
				send_vocab($urandom_range(VOCAB_N - 1, 3), 0);
			else
				send_fresh(2);
		end

		// dictionary full: new words are dropped, known ones still hit
		idle_on = 1'b1;
		send_fresh(70);
		while (items_sent < 1050) begin
			r = $urandom_range(99);
			if (r < 40)
				send_vocab($urandom_range(VOCAB_N - 1, 3), 0);
			else if (r < 70)
				send_fresh($urandom_range(4, 1));
			else if (r < 75)
				send_vocab($urandom_range(2), $urandom_range(4));
			else if (r < 85)
				send_delim();
			else
				send_noise();
		end
		send_item(8'($urandom_range(255)), 1'b1);
		wait_drained();
		repeat (200) @(negedge clk);

		$display("covered %0d items, %0d words: %0d new, %0d known, %0d dropped when full",
			items_sent, sb.results_seen, sb.new_words, sb.known_words, sb.dropped);
		$display("%0d truncated words, %0d empty delimiters, %0d entries in use, %0d mismatches",
			sb.truncated, sb.empty_delims, sb.stored, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
